### hdl/wdwr_pkg.sv
`timescale 1ns / 1ps

package wdwr_pkg;

	// Default sizes of the entry table
	localparam int ENTRY_COUNT_DEF = 16;
	localparam int WEIGHT_BITS_DEF = 8;

	// Fixed widths of the port fields
	localparam int IDX_PORT_W = 4;
	localparam int WGT_PORT_W = 8;
	localparam int POS_W      = 8;
	localparam int RND_W      = 64;
	localparam int STATUS_W   = 2;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DRAWN  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

endpackage

### hdl/wdwr_ram.sv
`timescale 1ns / 1ps

module wdwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/weighted_draw_without_replacement.sv
`timescale 1ns / 1ps

// Weighted draw without replacement over a table of ENTRY_COUNT weights.
// Raise start with cmd = load to write one entry's weight and clear its taken
// mark; the load word comes back with status loaded in the next cycle and busy
// stays low, so loads may follow each other in every cycle. A draw word raises
// busy for one pass over the weight RAM to total the untaken weights, a
// bit-serial restoring remainder of random_word by that total, and a second
// pass over the RAM to find the entry whose span holds the remainder. Each
// pass reads the entries through the registered RAM read. Every pass shares
// one adder and the single read port of the weight RAM. An empty pool ends the
// draw after the first pass with status empty. Each result is shown for
// exactly one cycle with done high and cannot be held off, so take it on that
// cycle. After reset all weights read as zero and no entry is taken; no
// clearing pass is needed since a per-entry written bit masks the RAM.

module weighted_draw_without_replacement
	import wdwr_pkg::*;
#(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  cmd,
	input  logic [IDX_PORT_W-1:0] entry_index,
	input  logic [WGT_PORT_W-1:0] entry_weight,
	input  logic [RND_W-1:0]      random_word,
	input  logic [POS_W-1:0]      draw_position,
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [IDX_PORT_W-1:0] chosen_index,
	output logic [POS_W-1:0]      chosen_position
);

	localparam int IDX_W = $clog2(ENTRY_COUNT);
	localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
	// Wide enough to hold both the port index and ENTRY_COUNT itself
	localparam int XW    = ((IDX_W > IDX_PORT_W) ? IDX_W : IDX_PORT_W) + 1;
	localparam int WX    = (WEIGHT_BITS > WGT_PORT_W) ? WEIGHT_BITS : WGT_PORT_W;
	// Pool total never exceeds ENTRY_COUNT * (2^WEIGHT_BITS - 1)
	localparam int TOT_W = WEIGHT_BITS + IDX_W;
	localparam int ADD_W = TOT_W + 2;
	localparam int DIV_W = $clog2(RND_W);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRY_COUNT);
	localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(RND_W - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SUM  = 4'b0010,
		S_DIV  = 4'b0100,
		S_WALK = 4'b1000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [DIV_W-1:0]   div_cnt_q;
	logic [ENTRY_COUNT-1:0] written_q;
	logic [ENTRY_COUNT-1:0] taken_q;

	logic [TOT_W-1:0]   acc_q;
	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   rem_q;
	logic [RND_W-1:0]   rnd_q;
	logic [POS_W-1:0]   pos_q;

	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [IDX_PORT_W-1:0] cidx_q;
	logic [POS_W-1:0]      cpos_q;

	// Load path
	logic                   accept;
	logic [XW-1:0]          ld_ext;
	logic [IDX_W-1:0]       ld_addr;
	logic                   ld_in_range;
	logic [WX-1:0]          wgt_ext;
	logic                   ram_we;
	logic [WEIGHT_BITS-1:0] ram_rdata;
	logic [IDX_W-1:0]       ram_raddr;

	// Shared adder
	logic [TOT_W-1:0] eff_w;
	logic [ADD_W-1:0] add_a;
	logic [ADD_W-1:0] add_b;
	logic             add_sub;
	logic [ADD_W-1:0] add_res;
	logic [TOT_W-1:0] acc_next;
	logic             pass_last;
	logic             hit;
	logic [XW-1:0]    hit_ext;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign ld_ext      = XW'(entry_index);
	assign ld_addr     = ld_ext[IDX_W-1:0];
	assign ld_in_range = (ld_ext < XW'(ENTRY_COUNT));
	assign wgt_ext     = WX'(entry_weight);
	assign ram_we      = accept && (cmd == CMD_LOAD) && ld_in_range;
	assign ram_raddr   = cnt_q[IDX_W-1:0];

	wdwr_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (ENTRY_COUNT)
	) u_weights (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ld_addr),
		.wdata (wgt_ext[WEIGHT_BITS-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Drop entries never written or already taken
	always_comb begin
		if (rd_vld_s1 && written_q[rd_idx_s1] && !taken_q[rd_idx_s1]) begin
			eff_w = TOT_W'(ram_rdata);
		end else begin
			eff_w = '0;
		end
	end

	// One adder serves the total, the remainder steps and the span walk
	always_comb begin
		case (state_q)
			S_DIV: begin
				add_a   = ADD_W'({rem_q, rnd_q[RND_W-1]});
				add_b   = ADD_W'(total_q);
				add_sub = 1'b1;
			end
			default: begin
				add_a   = ADD_W'(acc_q);
				add_b   = ADD_W'(eff_w);
				add_sub = 1'b0;
			end
		endcase
		add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
	end

	assign acc_next  = add_res[TOT_W-1:0];
	assign pass_last = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
	assign hit       = rd_vld_s1 && (rem_q < acc_next);
	assign hit_ext   = XW'(rd_idx_s1);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			div_cnt_q <= '0;
			written_q <= '0;
			taken_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q     <= '0;
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						if (cmd == CMD_LOAD) begin
							done_q <= 1'b1;
							if (ld_in_range) begin
								written_q[ld_addr] <= 1'b1;
								taken_q[ld_addr]   <= 1'b0;
							end
						end else begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM, S_WALK: begin
					// Issue the next RAM read while the previous one is summed
					if (cnt_q != CNT_END) begin
						cnt_q     <= cnt_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (state_q == S_SUM) begin
						if (pass_last) begin
							if (acc_next == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								div_cnt_q <= '0;
								state_q   <= S_DIV;
							end
						end
					end else if (hit) begin
						taken_q[rd_idx_s1] <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (pass_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					cnt_q     <= '0;
					rd_vld_s1 <= 1'b0;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_WALK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath and result registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
		case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				rem_q <= '0;
				if (accept) begin
					rnd_q <= random_word;
					pos_q <= draw_position;
					if (cmd == CMD_LOAD) begin
						status_q <= ST_LOADED;
						cidx_q   <= entry_index;
						cpos_q   <= '0;
					end
				end
			end
			S_SUM: begin
				acc_q <= acc_next;
				if (pass_last) begin
					total_q  <= acc_next;
					acc_q    <= '0;
					status_q <= ST_EMPTY;
					cidx_q   <= '0;
					cpos_q   <= '0;
				end
			end
			S_DIV: begin
				// Restoring step: keep the shifted remainder on a borrow
				if (add_res[ADD_W-1]) begin
					rem_q <= add_a[TOT_W-1:0];
				end else begin
					rem_q <= acc_next;
				end
				rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
			end
			S_WALK: begin
				acc_q <= acc_next;
				if (hit) begin
					status_q <= ST_DRAWN;
					cidx_q   <= hit_ext[IDX_PORT_W-1:0];
					cpos_q   <= pos_q;
				end else begin
					status_q <= ST_EMPTY;
					cidx_q   <= '0;
					cpos_q   <= '0;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign done            = done_q;
	assign status          = status_q;
	assign chosen_index    = cidx_q;
	assign chosen_position = cpos_q;

endmodule
